// ===== hw/rtl/lru_key_cache_defines.svh =====
// assertion macros shared by the lru key cache rtl
// no dependencies; included by modules that carry assertions
`ifndef LRU_KEY_CACHE_DEFINES_SVH
`define LRU_KEY_CACHE_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define LKC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LKC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lkc_pkg.sv =====
// shared constants and types for the lru key cache
// no dependencies
package lkc_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int KEY_BITS    = 32;
  localparam int KEY_W       = 32;
  localparam int CFG_W       = 4;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load_key;
    logic lookup;
    logic update;
  } cmd_t;

endpackage

// ===== hw/rtl/lkc_ctrl.sv =====
// sequencing state machine for the lru key cache
// depends on lkc_pkg
module lkc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output lkc_pkg::cmd_t cmd
);

  lkc_pkg::state_t state_r;
  lkc_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    busy         = 1'b1;
    case (state_r)
      lkc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_key = 1'b1;
          state_nxt    = lkc_pkg::ST_LOOKUP;
        end
      end
      lkc_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = lkc_pkg::ST_UPDATE;
      end
      lkc_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = lkc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lkc_datapath.sv =====
// recency stack, parallel key compare, occupancy and capacity registers
// depends on lkc_pkg and lru_key_cache_defines.svh
`include "lru_key_cache_defines.svh"

module lkc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lkc_pkg::cmd_t              cmd,
  input  logic [lkc_pkg::KEY_W-1:0]  in_key,
  input  logic                       cfg_we,
  input  logic [lkc_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic [lkc_pkg::KEY_W-1:0]  out_evicted_key
);

  localparam int N  = lkc_pkg::MAX_ENTRIES;
  localparam int KB = lkc_pkg::KEY_BITS;
  localparam int IW = lkc_pkg::IDX_W;
  localparam int CW = lkc_pkg::CNT_W;

  logic [KB-1:0] stack_r   [N];
  logic [KB-1:0] stack_nxt [N];
  logic [KB-1:0] key_r;
  logic [KB-1:0] bottom_r;
  logic [N-1:0]  match_r;
  logic [N-1:0]  match_nxt;
  logic [CW-1:0] occ_r;
  logic [CW-1:0] occ_nxt;
  logic [CW-1:0] cap_r;
  logic [CW-1:0] cap_nxt;

  logic                     out_valid_r;
  logic                     out_hit_r;
  logic                     out_evicted_r;
  logic [lkc_pkg::KEY_W-1:0] out_evk_r;
  logic [lkc_pkg::KEY_W-1:0] out_evk_nxt;

  logic          hit;
  logic          full;
  logic [IW-1:0] hit_pos;
  logic [IW-1:0] pos;

  // lookup phase: compare every live entry against the key
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_nxt[i] = (CW'(i) < occ_r) && (stack_r[i] == key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= KB'(in_key);
    end
    if (cmd.lookup) begin
      match_r  <= match_nxt;
      // least recent slot when the store is full
      bottom_r <= stack_r[IW'(cap_r - CW'(1))];
    end
  end

  // update phase: pick the slot that leaves the stack
  always_comb begin
    hit     = |match_r;
    full    = (occ_r >= cap_r);
    hit_pos = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_pos = IW'(i);
      end
    end
    if (hit) begin
      pos     = hit_pos;
      occ_nxt = occ_r;
    end else if (full) begin
      pos     = IW'(cap_r - CW'(1));
      occ_nxt = cap_r;
    end else begin
      pos     = IW'(occ_r);
      occ_nxt = occ_r + CW'(1);
    end
    out_evk_nxt = (!hit && full) ? lkc_pkg::KEY_W'(bottom_r) : '0;
  end

  // entries above the vacated slot move down one, new key on top
  always_comb begin
    stack_nxt[0] = key_r;
    for (int i = 1; i < N; i++) begin
      stack_nxt[i] = (IW'(i) <= pos) ? stack_r[i-1] : stack_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < N; i++) begin
        stack_r[i] <= stack_nxt[i];
      end
      out_hit_r     <= hit;
      out_evicted_r <= !hit && full;
      out_evk_r     <= out_evk_nxt;
    end
  end

  // capacity only changes while the store is empty, then clamps
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we && (occ_r == '0)) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CW'(1);
      end else if (int'(cfg_wdata) > N) begin
        cap_nxt = CW'(N);
      end else begin
        cap_nxt = CW'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      cap_r       <= CW'(N);
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= cmd.update;
      if (cmd.update) begin
        occ_r <= occ_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evk_r;

  `LKC_ASSERT_ALWAYS(a_occ_le_cap, clk, rst_n, occ_r <= cap_r, "occupancy above capacity")
  `LKC_ASSERT_ALWAYS(a_cap_range, clk, rst_n, (cap_r != '0) && (int'(cap_r) <= N), "capacity out of range")
  `LKC_ASSERT_NEXT(a_update_strobe, clk, rst_n, cmd.update, out_valid_r, "result word not strobed after update")
  `LKC_ASSERT_SAME(a_hit_no_evict, clk, rst_n, out_valid_r && out_hit_r, !out_evicted_r, "eviction reported on a hit")
  `LKC_ASSERT_SAME(a_evict_full, clk, rst_n, out_valid_r && out_evicted_r, occ_r == cap_r, "eviction with store not full")
  `LKC_ASSERT_SAME(a_evk_zero, clk, rst_n, out_valid_r && !out_evicted_r, out_evk_r == '0, "evicted key not zero without eviction")

endmodule

// ===== hw/rtl/lru_key_cache.sv =====
// lru key cache, fully associative store of keys kept in recency order
// depends on lkc_pkg, lkc_ctrl and lkc_datapath
//
// input: a key word is taken at a clock edge with start high and busy low.
// busy stays high after each accepted word, first in the lookup state, which
// compares the key against all live entries at once, then in the update state,
// which shifts the recency stack and loads the result registers. out_valid is
// high for exactly one cycle, the cycle after the update, carrying out_hit,
// out_evicted and out_evicted_key (zero unless a miss on a full store dropped
// the least recent key). a new word is taken only once the block is back in
// idle, after the compare and the stack update of the last word are done.
// the result has no back-pressure; the receiver must take it when strobed.
// cfg_we writes capacity (cfg_wdata, clamped to 1..MAX_ENTRIES), and only
// takes effect while the store is empty; write it while the block is idle.
// synchronous reset (rst_n low) empties the store and sets capacity to the
// maximum; stack contents are not cleared, unused slots are never read.
module lru_key_cache (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lkc_pkg::KEY_W-1:0]  in_key,
  input  logic                       cfg_we,
  input  logic [lkc_pkg::CFG_W-1:0]  cfg_wdata,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic [lkc_pkg::KEY_W-1:0]  out_evicted_key
);

  lkc_pkg::cmd_t cmd;

  lkc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lkc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_key          (in_key),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for lru_key_cache: directed and random key words
// checked against a recency-stack predictor kept in the bench
// depends on lkc_pkg and the lru_key_cache rtl
module tb_top;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int POOL_SIZE    = 12;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic                      hit;
    logic                      evicted;
    logic [lkc_pkg::KEY_W-1:0] evicted_key;
  } lookup_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [lkc_pkg::KEY_W-1:0] in_key = '0;
  logic                      cfg_we = 1'b0;
  logic [lkc_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic                      out_valid;
  logic                      out_hit;
  logic                      out_evicted;
  logic [lkc_pkg::KEY_W-1:0] out_evicted_key;

  // predictor state: most recent key at slot 0
  logic [lkc_pkg::KEY_W-1:0] lru_keys [lkc_pkg::MAX_ENTRIES];
  int unsigned               fill_cnt = 0;
  int unsigned               cap_now = lkc_pkg::MAX_ENTRIES;

  lookup_result_t            pending_results [$];
  logic [lkc_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int                        err_count = 0;
  int                        cycle_count = 0;

  lru_key_cache u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_key          (in_key),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               pending_results.size());
      $display("[lru_key_cache] ERROR");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // updates the recency stack and returns what the block should report
  function automatic lookup_result_t predict_lookup(input logic [lkc_pkg::KEY_W-1:0] k);
    lookup_result_t r;
    int unsigned    pos;
    r = '0;
    pos = fill_cnt;
    for (int unsigned i = 0; i < fill_cnt; i++) begin
      if (!r.hit && lru_keys[i] == k) begin
        pos = i;
        r.hit = 1'b1;
      end
    end
    if (!r.hit) begin
      if (fill_cnt >= cap_now) begin
        pos = cap_now - 1;
        r.evicted = 1'b1;
        r.evicted_key = lru_keys[pos];
        fill_cnt = cap_now;
      end else begin
        pos = fill_cnt;
        fill_cnt++;
      end
    end
    for (int unsigned i = pos; i > 0; i--) lru_keys[i] = lru_keys[i - 1];
    lru_keys[0] = k;
    return r;
  endfunction

  // capacity only moves while the store is empty, clamped to 1..MAX_ENTRIES
  task automatic write_capacity(input logic [lkc_pkg::CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    if (fill_cnt == 0) begin
      if (v == 0) cap_now = 1;
      else if (v > lkc_pkg::MAX_ENTRIES) cap_now = lkc_pkg::MAX_ENTRIES;
      else cap_now = v;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // start stays high across back-to-back words; callers lower it to idle
  task automatic send_key(input logic [lkc_pkg::KEY_W-1:0] k);
    start <= 1'b1;
    in_key <= k;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_lookup(k));
  endtask

  task automatic idle_sender(input int pct);
    while ($urandom_range(99, 0) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected word hit=%b evicted=%b key=%h",
                               out_hit, out_evicted, out_evicted_key));
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit)
          report_error($sformatf("hit got %b want %b", out_hit, want.hit));
        if (out_evicted !== want.evicted)
          report_error($sformatf("evicted got %b want %b", out_evicted, want.evicted));
        if (out_evicted_key !== want.evicted_key)
          report_error($sformatf("evicted_key got %h want %h", out_evicted_key,
                                 want.evicted_key));
      end
    end
  end

  // saturating writes first, then the capacity this run keeps
  task automatic test_capacity_setup();
    write_capacity('0);
    write_capacity('1);
    write_capacity(lkc_pkg::CFG_W'($urandom_range(15, 0)));
    $display("capacity for this run: %0d", cap_now);
  endtask

  task automatic test_directed();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    // most recent, then older entries, then the oldest ones
    send_key(32'h0000_0001);
    send_key(32'h5555_5555);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    for (int i = 2; i < 2 + lkc_pkg::MAX_ENTRIES; i++) send_key(lkc_pkg::KEY_W'(i));
    // keys a single bit off earlier keys, then two earlier keys sent again
    send_key(32'h0000_0008);
    send_key(32'h8000_0002);
    send_key(32'h7FFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_random_phase(input int n_words, input int idle_pct);
    int unsigned               span;
    logic [lkc_pkg::KEY_W-1:0] k;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    // a pool a bit larger than the capacity keeps hits and evictions mixed
    span = (cap_now + 3 > POOL_SIZE) ? POOL_SIZE : cap_now + 3;
    for (int n = 0; n < n_words; n++) begin
      idle_sender(idle_pct);
      if ($urandom_range(99, 0) < 75) begin
        k = key_pool[$urandom_range(span - 1, 0)];
        if ($urandom_range(9, 0) == 0) k[$urandom_range(lkc_pkg::KEY_W - 1, 0)] ^= 1'b1;
      end else begin
        k = $urandom;
      end
      send_key(k);
    end
    drain_results();
    // store is not empty any more, so this write must not take effect
    write_capacity(lkc_pkg::CFG_W'($urandom_range(15, 0)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_capacity_setup();
    test_directed();
    test_random_phase(470, 22);
    test_random_phase(470, 88);
    test_random_phase(460, 0);
    if (err_count == 0) begin
      $display("[lru_key_cache] OK");
    end else begin
      $display("[lru_key_cache] ERROR");
    end
    $finish;
  end

endmodule
